// ===== sv/h2gfc_pkg.sv =====
// types, codes and constants shared by the frame classifier
package h2gfc_pkg;

	localparam int unsigned POS_W    = 25;
	localparam int unsigned LEN_W    = 24;
	localparam int unsigned MSG_W    = 32;
	localparam int unsigned OUT_CNT_W = 32;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] HDR_LEN = POS_W'(9);
	localparam logic [POS_W-1:0] PREFACE_SIZE = POS_W'(24);

	localparam logic [7:0] FLAG_PADDED   = 8'h08;
	localparam logic [7:0] FLAG_PRIORITY = 8'h20;

	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 24'd16384;

	// frame type codes
	localparam logic [7:0] FT_DATA          = 8'd0;
	localparam logic [7:0] FT_HEADERS       = 8'd1;
	localparam logic [7:0] FT_STREAM_RESET  = 8'd3;
	localparam logic [7:0] FT_SETTINGS      = 8'd4;
	localparam logic [7:0] FT_PING          = 8'd6;
	localparam logic [7:0] FT_GOAWAY        = 8'd7;
	localparam logic [7:0] FT_WINDOW_UPDATE = 8'd8;
	localparam logic [7:0] FT_LAST_KNOWN    = 8'd9;

	typedef enum logic [1:0] {
		ST_SUCCESS      = 2'd0,
		ST_INSUFFICIENT = 2'd1,
		ST_INVALID      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_REQUEST  = 2'd1,
		KIND_RESPONSE = 2'd2
	} kind_t;

	// buffer state as it stands after the last byte
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             preface_ok;
		logic [LEN_W-1:0] length;
		logic [7:0]       ftype;
		logic [7:0]       flags;
		logic             stream_zero;
		logic             stream_odd;
		logic [7:0]       pad;
		logic [MSG_W-1:0] msg_len;
		logic [7:0]       lead_byte;
	} frame_snap_t;

	function automatic logic [7:0] preface_byte(input logic [4:0] idx);
		logic [7:0] r;
		unique case (idx)
			5'd0:  r = 8'h50;
			5'd1:  r = 8'h52;
			5'd2:  r = 8'h49;
			5'd3:  r = 8'h20;
			5'd4:  r = 8'h2A;
			5'd5:  r = 8'h20;
			5'd6:  r = 8'h48;
			5'd7:  r = 8'h54;
			5'd8:  r = 8'h54;
			5'd9:  r = 8'h50;
			5'd10: r = 8'h2F;
			5'd11: r = 8'h32;
			5'd12: r = 8'h2E;
			5'd13: r = 8'h30;
			5'd14: r = 8'h0D;
			5'd15: r = 8'h0A;
			5'd16: r = 8'h0D;
			5'd17: r = 8'h0A;
			5'd18: r = 8'h53;
			5'd19: r = 8'h4D;
			5'd20: r = 8'h0D;
			5'd21: r = 8'h0A;
			5'd22: r = 8'h0D;
			5'd23: r = 8'h0A;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/http2_grpc_frame_classifier.sv =====
// http/2 frame classifier with grpc message accounting, one byte per cycle
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  in       | sink      | in_valid / in_stall     | data_byte[7:0], last
//  out      | source    | out_valid / out_stall   | status, counted, message_kind, 3 totals
//  cfg      | sink      | cfg_wr_en               | cfg_wr_data[23:0] (frame size limit)
//
//  one byte request per cycle while in_stall is low; the last byte passes stage 1 and stage 2 before out_valid rises
//  stage 1 registers the byte, stage 2 holds the finished header snapshot, stage 3 is the result
//  all stages advance together; they hold only while a result sits stalled at the output
//  async reset clears buffer state, counters and the frame size limit (to 16384)
//  a buffer with no last byte keeps accumulating; its position saturates
module http2_grpc_frame_classifier #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        counted,
	output logic [1:0]  message_kind,
	output logic [31:0] call_count,
	output logic [31:0] request_byte_total,
	output logic [31:0] response_byte_total
);

	localparam int unsigned POS_W = h2gfc_pkg::POS_W;
	localparam int unsigned LEN_W = h2gfc_pkg::LEN_W;
	localparam int unsigned MSG_W = h2gfc_pkg::MSG_W;

	// pipeline advance: everything moves unless the result register is held
	logic adv;

	// stage 1: registered input byte
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-buffer state
	logic [POS_W-1:0] pos_q;
	logic             preface_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       type_q;
	logic [7:0]       flags_q;
	logic [30:0]      stream_q;
	logic [7:0]       pad_q;
	logic [MSG_W-1:0] msg_q;
	logic [7:0]       first_q;
	logic [23:0]      max_frame_q;

	// next values of the buffer state for the byte in stage 1
	logic             preface_nxt;
	logic [LEN_W-1:0] len_nxt;
	logic [7:0]       type_nxt;
	logic [7:0]       flags_nxt;
	logic [30:0]      stream_nxt;
	logic [7:0]       pad_nxt;
	logic [MSG_W-1:0] msg_nxt;
	logic [7:0]       first_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] pay_ofs;
	logic [POS_W-1:0] msg_ofs;
	logic             in_payload;
	logic             padded_cur;

	// stage 2: snapshot of the finished buffer
	logic                   valid_s2;
	h2gfc_pkg::frame_snap_t snap_s2;

	// classification of stage 2
	h2gfc_pkg::status_t st_c;
	h2gfc_pkg::kind_t   kind_c;
	logic               cnt_c;
	logic               prio_c;
	logic               padded_c;
	logic [2:0]         hdr_off;
	logic [LEN_W-1:0]   hdr_need;
	logic [LEN_W:0]     data_pad_need;
	logic [MSG_W:0]     data_msg_need;
	logic [POS_W:0]     frame_end;
	logic               tag_ok;

	// stage 3: result register
	logic               valid_s3;
	h2gfc_pkg::status_t status_s3;
	logic               counted_s3;
	h2gfc_pkg::kind_t   kind_s3;

	// running totals
	logic [COUNT_BITS-1:0] calls_q;
	logic [COUNT_BITS-1:0] req_bytes_q;
	logic [COUNT_BITS-1:0] rsp_bytes_q;

	assign adv      = !valid_s3 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= h2gfc_pkg::MAX_FRAME_RESET;
		end else if (cfg_wr_en) begin
			max_frame_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// byte decode: header fields by position, then the few payload bytes we care about
	always_comb begin
		preface_nxt = preface_q;
		len_nxt     = len_q;
		type_nxt    = type_q;
		flags_nxt   = flags_q;
		stream_nxt  = stream_q;
		pad_nxt     = pad_q;
		msg_nxt     = msg_q;
		first_nxt   = first_q;
		padded_cur  = (flags_q & h2gfc_pkg::FLAG_PADDED) != 8'd0;
		pay_ofs     = pos_q - h2gfc_pkg::HDR_LEN;
		msg_ofs     = pay_ofs - (padded_cur ? POS_W'(1) : POS_W'(0));
		in_payload  = (pos_q >= h2gfc_pkg::HDR_LEN) && (pay_ofs < POS_W'(len_q));
		pos_nxt     = (pos_q == h2gfc_pkg::POS_MAX) ? pos_q : pos_q + POS_W'(1);

		if (pos_q < h2gfc_pkg::PREFACE_SIZE &&
		    byte_s1 != h2gfc_pkg::preface_byte(pos_q[4:0])) begin
			preface_nxt = 1'b0;
		end

		if (pos_q < POS_W'(3)) begin
			len_nxt = {len_q[15:0], byte_s1};
		end else if (pos_q == POS_W'(3)) begin
			type_nxt = byte_s1;
		end else if (pos_q == POS_W'(4)) begin
			flags_nxt = byte_s1;
		end else if (pos_q < h2gfc_pkg::HDR_LEN) begin
			stream_nxt = {stream_q[22:0], byte_s1};
		end else if (in_payload) begin
			if (type_q == h2gfc_pkg::FT_HEADERS) begin
				// pad length sits after the priority block when present
				if (padded_cur && pay_ofs ==
				    (((flags_q & h2gfc_pkg::FLAG_PRIORITY) != 8'd0) ? POS_W'(5) : POS_W'(0))) begin
					pad_nxt = byte_s1;
				end
			end else if (type_q == h2gfc_pkg::FT_DATA) begin
				if (padded_cur && pay_ofs == POS_W'(0)) begin
					pad_nxt = byte_s1;
				end else if (msg_ofs >= POS_W'(1) && msg_ofs <= POS_W'(4)) begin
					// grpc length prefix, big endian
					msg_nxt = {msg_q[MSG_W-9:0], byte_s1};
				end else if (msg_ofs == POS_W'(5)) begin
					first_nxt = byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			preface_q <= 1'b1;
			len_q     <= '0;
			type_q    <= '0;
			flags_q   <= '0;
			stream_q  <= '0;
			pad_q     <= '0;
			msg_q     <= '0;
			first_q   <= '0;
		end else if (adv && valid_s1) begin
			if (last_s1) begin
				// buffer done: start the next one clean
				pos_q     <= '0;
				preface_q <= 1'b1;
				len_q     <= '0;
				type_q    <= '0;
				flags_q   <= '0;
				stream_q  <= '0;
				pad_q     <= '0;
				msg_q     <= '0;
				first_q   <= '0;
			end else begin
				pos_q     <= pos_nxt;
				preface_q <= preface_nxt;
				len_q     <= len_nxt;
				type_q    <= type_nxt;
				flags_q   <= flags_nxt;
				stream_q  <= stream_nxt;
				pad_q     <= pad_nxt;
				msg_q     <= msg_nxt;
				first_q   <= first_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && last_s1) begin
			snap_s2.pos         <= pos_q;
			snap_s2.preface_ok  <= preface_nxt;
			snap_s2.length      <= len_nxt;
			snap_s2.ftype       <= type_nxt;
			snap_s2.flags       <= flags_nxt;
			snap_s2.stream_zero <= stream_nxt == 31'd0;
			snap_s2.stream_odd  <= stream_nxt[0];
			snap_s2.pad         <= pad_nxt;
			snap_s2.msg_len     <= msg_nxt;
			snap_s2.lead_byte   <= first_nxt;
		end
	end

	// classification of a finished buffer; pos is the index of its last byte
	always_comb begin
		st_c     = h2gfc_pkg::ST_SUCCESS;
		kind_c   = h2gfc_pkg::KIND_NONE;
		cnt_c    = 1'b0;
		prio_c   = (snap_s2.flags & h2gfc_pkg::FLAG_PRIORITY) != 8'd0;
		padded_c = (snap_s2.flags & h2gfc_pkg::FLAG_PADDED) != 8'd0;
		hdr_off  = prio_c ? 3'd5 : 3'd0;
		hdr_need = LEN_W'(hdr_off) + LEN_W'(1) + LEN_W'(snap_s2.pad);
		// padded data: pad length byte plus trailing padding
		data_pad_need = padded_c ? (LEN_W+1)'(snap_s2.pad) + (LEN_W+1)'(1) : '0;
		// data part must hold the 5-byte prefix and the whole message
		data_msg_need = (MSG_W+1)'(snap_s2.msg_len) + (MSG_W+1)'(data_pad_need)
		              + (MSG_W+1)'(5);
		frame_end = (POS_W+1)'(snap_s2.length) + (POS_W+1)'(8);
		// protobuf tag: nonzero field number, known wire type
		tag_ok = (snap_s2.lead_byte[7:3] != 5'd0) && (snap_s2.lead_byte[2:0] <= 3'd5);

		if (snap_s2.pos < POS_W'(8)) begin
			st_c = h2gfc_pkg::ST_INSUFFICIENT;
		end else if (snap_s2.pos >= POS_W'(23) && snap_s2.preface_ok) begin
			st_c = h2gfc_pkg::ST_SUCCESS;
		end else if (snap_s2.length > max_frame_q ||
		             snap_s2.ftype > h2gfc_pkg::FT_LAST_KNOWN) begin
			st_c = h2gfc_pkg::ST_INVALID;
		end else if (snap_s2.stream_zero &&
		             !(snap_s2.ftype inside {h2gfc_pkg::FT_SETTINGS, h2gfc_pkg::FT_PING,
		                                     h2gfc_pkg::FT_GOAWAY,
		                                     h2gfc_pkg::FT_WINDOW_UPDATE})) begin
			st_c = h2gfc_pkg::ST_INVALID;
		end else if ((POS_W+1)'(snap_s2.pos) < frame_end) begin
			st_c = h2gfc_pkg::ST_INSUFFICIENT;
		end else begin
			case (snap_s2.ftype) inside
				h2gfc_pkg::FT_HEADERS: begin
					if (snap_s2.length != '0) begin
						if ((prio_c && snap_s2.length < LEN_W'(5)) ||
						    (padded_c && (LEN_W'(hdr_off) >= snap_s2.length ||
						                  hdr_need > snap_s2.length))) begin
							st_c = h2gfc_pkg::ST_INSUFFICIENT;
						end
					end
				end
				h2gfc_pkg::FT_DATA: begin
					if (snap_s2.length != '0) begin
						if (data_pad_need > (LEN_W+1)'(snap_s2.length)) begin
							st_c = h2gfc_pkg::ST_INSUFFICIENT;
						end else if (snap_s2.msg_len != '0 && tag_ok &&
						             (MSG_W+1)'(snap_s2.length) >= data_msg_need) begin
							cnt_c  = 1'b1;
							kind_c = snap_s2.stream_odd ? h2gfc_pkg::KIND_REQUEST
							                            : h2gfc_pkg::KIND_RESPONSE;
						end
					end
				end
				h2gfc_pkg::FT_STREAM_RESET, h2gfc_pkg::FT_SETTINGS, h2gfc_pkg::FT_PING,
				h2gfc_pkg::FT_GOAWAY, h2gfc_pkg::FT_WINDOW_UPDATE: begin
					cnt_c = 1'b1;
				end
				default: begin
					st_c = h2gfc_pkg::ST_SUCCESS;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			calls_q     <= '0;
			req_bytes_q <= '0;
			rsp_bytes_q <= '0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			if (valid_s2 && cnt_c) begin
				calls_q <= calls_q + COUNT_BITS'(1);
				if (kind_c == h2gfc_pkg::KIND_REQUEST) begin
					req_bytes_q <= req_bytes_q + COUNT_BITS'(snap_s2.msg_len);
				end else if (kind_c == h2gfc_pkg::KIND_RESPONSE) begin
					rsp_bytes_q <= rsp_bytes_q + COUNT_BITS'(snap_s2.msg_len);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			status_s3  <= st_c;
			counted_s3 <= cnt_c;
			kind_s3    <= kind_c;
		end
	end

	// totals only move when a result loads, so they hold with a stalled result
	assign out_valid           = valid_s3;
	assign status              = status_s3;
	assign counted             = counted_s3;
	assign message_kind        = kind_s3;
	assign call_count          = 32'(calls_q);
	assign request_byte_total  = 32'(req_bytes_q);
	assign response_byte_total = 32'(rsp_bytes_q);

	// a counted buffer is always a successful one
	a_counted_success: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && counted_s3 |-> status_s3 == h2gfc_pkg::ST_SUCCESS)
		else $error("counted result without success status");

	// a message kind only comes with a counted call
	a_kind_counted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && kind_s3 != h2gfc_pkg::KIND_NONE |-> counted_s3)
		else $error("message kind set on uncounted result");

	// the call counter steps by one for each counted result
	a_call_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && cnt_c |=> calls_q == $past(calls_q) + COUNT_BITS'(1))
		else $error("call counter did not advance");

	// the byte position restarts after the last byte of a buffer
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && last_s1 |=> pos_q == '0)
		else $error("byte position not cleared after last byte");

endmodule

// ===== tb/tb_http2_grpc_frame_classifier.sv =====
// self-checking testbench for the http/2 grpc frame classifier: directed and random byte buffers against a predictor
module tb_http2_grpc_frame_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	// frame types the package leaves unnamed
	localparam logic [7:0] FT_PRIORITY      = 8'd2;
	localparam logic [7:0] FT_PUSH_PROMISE  = 8'd5;
	localparam logic [7:0] FT_CONTINUATION  = h2gfc_pkg::FT_LAST_KNOWN;
	localparam logic [7:0] FT_FIRST_UNKNOWN = h2gfc_pkg::FT_LAST_KNOWN + 8'd1;

	// "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n", first byte in the top bits
	localparam logic [191:0] CONN_PREFACE = {"PRI * HTTP/2.0", 8'h0D, 8'h0A, 8'h0D, 8'h0A,
		"SM", 8'h0D, 8'h0A, 8'h0D, 8'h0A};

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 8;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_LIGHT,
		SINK_HEAVY,
		SINK_PERIODIC
	} sink_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	typedef struct packed {
		h2gfc_pkg::status_t status;
		logic               counted;
		h2gfc_pkg::kind_t   kind;
		logic [31:0]        calls;
		logic [31:0]        req_bytes;
		logic [31:0]        resp_bytes;
	} frame_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        counted;
	logic [1:0]  message_kind;
	logic [31:0] call_count;
	logic [31:0] request_byte_total;
	logic [31:0] response_byte_total;

	http2_grpc_frame_classifier DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.data_byte          (data_byte),
		.last               (last),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.counted            (counted),
		.message_kind       (message_kind),
		.call_count         (call_count),
		.request_byte_total (request_byte_total),
		.response_byte_total(response_byte_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// predictor state: the buffer being assembled, the limit and the totals
	// ---------------------------------------------------------------------
	logic [23:0] max_frame = h2gfc_pkg::MAX_FRAME_RESET;
	logic [24:0] buf_pos;
	logic        pre_ok;
	logic [23:0] hdr_len;
	logic [7:0]  hdr_type;
	logic [7:0]  hdr_flags;
	logic [30:0] hdr_stream;
	logic [7:0]  pad_len;
	logic [31:0] grpc_len;
	logic [7:0]  tag_byte;
	logic [31:0] call_tally = '0;
	logic [31:0] req_tally = '0;
	logic [31:0] resp_tally = '0;

	frame_verdict_t verdict_q[$];
	byte_req_t      pending_q[$];
	logic [7:0]     frame_buf[$];
	int unsigned    bytes_queued = 0;
	int unsigned    mismatch_count = 0;

	function automatic void restart_buffer();
		buf_pos = '0;
		pre_ok = 1'b1;
		hdr_len = '0;
		hdr_type = '0;
		hdr_flags = '0;
		hdr_stream = '0;
		pad_len = '0;
		grpc_len = '0;
		tag_byte = '0;
	endfunction

	// fold one byte into the header fields or the position-indexed payload fields
	function automatic void absorb_byte(input logic [24:0] p, input logic [7:0] b);
		logic [24:0] q;
		logic [24:0] at;
		logic [24:0] base;
		logic        padded;
		int          idx;
		idx = int'(p[4:0]);
		if (p < h2gfc_pkg::PREFACE_SIZE && b != CONN_PREFACE[8*(23-idx) +: 8])
			pre_ok = 1'b0;
		if (p < 25'd3) begin
			hdr_len = {hdr_len[15:0], b};
		end else if (p == 25'd3) begin
			hdr_type = b;
		end else if (p == 25'd4) begin
			hdr_flags = b;
		end else if (p < h2gfc_pkg::HDR_LEN) begin
			hdr_stream = {hdr_stream[22:0], b};
		end else begin
			q = p - h2gfc_pkg::HDR_LEN;
			padded = (hdr_flags & h2gfc_pkg::FLAG_PADDED) != 0;
			// bytes past the declared payload change nothing
			if (q < 25'(hdr_len)) begin
				if (hdr_type == h2gfc_pkg::FT_HEADERS) begin
					at = ((hdr_flags & h2gfc_pkg::FLAG_PRIORITY) != 0) ? 25'd5 : 25'd0;
					if (padded && q == at)
						pad_len = b;
				end else if (hdr_type == h2gfc_pkg::FT_DATA) begin
					base = padded ? 25'd1 : 25'd0;
					if (padded && q == 25'd0)
						pad_len = b;
					else if (q >= base + 25'd1 && q <= base + 25'd4)
						grpc_len = {grpc_len[23:0], b};
					else if (q == base + 25'd5)
						tag_byte = b;
				end
			end
		end
	endfunction

	// verdict for the finished buffer; bumps the totals when a call is counted
	function automatic void classify_buffer(input longint unsigned total,
			output h2gfc_pkg::status_t st, output logic cnt, output h2gfc_pkg::kind_t kind);
		longint unsigned len;
		longint unsigned off;
		longint unsigned pad;
		longint unsigned dlen;
		len = 64'(hdr_len);
		cnt = 1'b0;
		kind = h2gfc_pkg::KIND_NONE;
		st = h2gfc_pkg::ST_SUCCESS;
		if (total < 64'(h2gfc_pkg::HDR_LEN)) begin
			st = h2gfc_pkg::ST_INSUFFICIENT;
			return;
		end
		if (total >= 64'(h2gfc_pkg::PREFACE_SIZE) && pre_ok)
			return;
		if (hdr_len > max_frame || hdr_type > h2gfc_pkg::FT_LAST_KNOWN) begin
			st = h2gfc_pkg::ST_INVALID;
			return;
		end
		// only connection-level control frames may sit on stream zero
		if (hdr_stream == '0 && hdr_type != h2gfc_pkg::FT_SETTINGS &&
				hdr_type != h2gfc_pkg::FT_PING && hdr_type != h2gfc_pkg::FT_GOAWAY &&
				hdr_type != h2gfc_pkg::FT_WINDOW_UPDATE) begin
			st = h2gfc_pkg::ST_INVALID;
			return;
		end
		if (total < 64'(h2gfc_pkg::HDR_LEN) + len) begin
			st = h2gfc_pkg::ST_INSUFFICIENT;
			return;
		end
		if (hdr_type == h2gfc_pkg::FT_HEADERS) begin
			off = 0;
			if (len == 0)
				return;
			if ((hdr_flags & h2gfc_pkg::FLAG_PRIORITY) != 0) begin
				if (len < 5) begin
					st = h2gfc_pkg::ST_INSUFFICIENT;
					return;
				end
				off = 5;
			end
			if ((hdr_flags & h2gfc_pkg::FLAG_PADDED) != 0) begin
				if (off >= len) begin
					st = h2gfc_pkg::ST_INSUFFICIENT;
					return;
				end
				off++;
				if (off + 64'(pad_len) > len)
					st = h2gfc_pkg::ST_INSUFFICIENT;
			end
			return;
		end
		if (hdr_type == h2gfc_pkg::FT_DATA) begin
			off = 0;
			pad = 0;
			if (len == 0)
				return;
			if ((hdr_flags & h2gfc_pkg::FLAG_PADDED) != 0) begin
				pad = 64'(pad_len);
				off = 1;
				if (off + pad > len) begin
					st = h2gfc_pkg::ST_INSUFFICIENT;
					return;
				end
			end
			// trailing padding is not data
			dlen = len - off - pad;
			if (dlen >= 5 && grpc_len != '0 && dlen >= 64'd5 + 64'(grpc_len) &&
					tag_byte[7:3] != '0 && tag_byte[2:0] <= 3'd5) begin
				cnt = 1'b1;
				if (hdr_stream[0]) begin
					kind = h2gfc_pkg::KIND_REQUEST;
					req_tally = req_tally + grpc_len;
				end else begin
					kind = h2gfc_pkg::KIND_RESPONSE;
					resp_tally = resp_tally + grpc_len;
				end
				call_tally = call_tally + 32'd1;
			end
			return;
		end
		if (hdr_type == h2gfc_pkg::FT_STREAM_RESET || hdr_type == h2gfc_pkg::FT_SETTINGS ||
				hdr_type == h2gfc_pkg::FT_PING || hdr_type == h2gfc_pkg::FT_GOAWAY ||
				hdr_type == h2gfc_pkg::FT_WINDOW_UPDATE) begin
			cnt = 1'b1;
			call_tally = call_tally + 32'd1;
		end
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic lst);
		logic [24:0]        p;
		h2gfc_pkg::status_t st;
		logic               cnt;
		h2gfc_pkg::kind_t   kind;
		frame_verdict_t     v;
		p = buf_pos;
		absorb_byte(p, b);
		// position saturates on very long buffers
		if (buf_pos != h2gfc_pkg::POS_MAX)
			buf_pos = buf_pos + 25'd1;
		if (lst) begin
			classify_buffer(64'(p) + 64'd1, st, cnt, kind);
			v.status = st;
			v.counted = cnt;
			v.kind = kind;
			v.calls = call_tally;
			v.req_bytes = req_tally;
			v.resp_bytes = resp_tally;
			verdict_q.push_back(v);
			restart_buffer();
		end
	endfunction

	// ---------------------------------------------------------------------
	// buffer builders: assemble bytes in frame_buf, then hand them to the driver
	// ---------------------------------------------------------------------
	task automatic commit_buffer();
		byte_req_t r;
		foreach (frame_buf[i]) begin
			r.data = frame_buf[i];
			r.last = (i == frame_buf.size() - 1);
			pending_q.push_back(r);
		end
		bytes_queued += frame_buf.size();
		frame_buf.delete();
	endtask

	task automatic put_random(input int unsigned n);
		repeat (n) frame_buf.push_back(8'($urandom));
	endtask

	task automatic put_preface();
		for (int i = 0; i < 24; i++)
			frame_buf.push_back(CONN_PREFACE[8*(23-i) +: 8]);
	endtask

	task automatic put_header(input logic [23:0] len, input logic [7:0] ftype,
			input logic [7:0] flags, input logic [31:0] stream);
		frame_buf.push_back(len[23:16]);
		frame_buf.push_back(len[15:8]);
		frame_buf.push_back(len[7:0]);
		frame_buf.push_back(ftype);
		frame_buf.push_back(flags);
		for (int i = 3; i >= 0; i--)
			frame_buf.push_back(stream[8*i +: 8]);
	endtask

	// data frame holding one grpc message: [pad length] flag, length, body, [padding]
	task automatic data_frame(input logic [31:0] stream, input logic [7:0] flags,
			input logic [7:0] pad_n, input logic [31:0] msg_len, input int unsigned body_n,
			input logic [7:0] tag);
		logic [7:0] pl[$];
		logic       padded;
		padded = (flags & h2gfc_pkg::FLAG_PADDED) != 0;
		if (padded)
			pl.push_back(pad_n);
		pl.push_back(8'($urandom_range(0, 1)));
		for (int i = 3; i >= 0; i--)
			pl.push_back(msg_len[8*i +: 8]);
		for (int i = 0; i < body_n; i++)
			pl.push_back((i == 0) ? tag : 8'($urandom));
		if (padded)
			repeat (pad_n) pl.push_back(8'($urandom));
		put_header(24'(pl.size()), h2gfc_pkg::FT_DATA, flags, stream);
		foreach (pl[i]) frame_buf.push_back(pl[i]);
	endtask

	task automatic control_frame(input logic [7:0] ftype, input logic [31:0] stream);
		put_header(24'd4, ftype, 8'h00, stream);
		put_random(4);
		commit_buffer();
	endtask

	function automatic logic [31:0] rand_stream();
		case ($urandom_range(0, 9))
			0: return 32'($urandom_range(0, 1)) << 31;  // stream zero, reserved bit random
			1, 2, 3: return 32'($urandom_range(1, 9));
			default: return $urandom;
		endcase
	endfunction

	task automatic directed_buffers();
		// too short to hold a frame header
		put_random(1);
		commit_buffer();
		put_random(8);
		commit_buffer();
		// connection preface: exact, with trailing bytes, one byte short
		put_preface();
		commit_buffer();
		put_preface();
		put_random(3);
		commit_buffer();
		put_preface();
		void'(frame_buf.pop_back());
		commit_buffer();
		// good grpc messages: request, response, padded
		data_frame(32'd1, 8'h00, 8'd0, 32'd4, 4, 8'h0A);
		commit_buffer();
		data_frame(32'd2, 8'h00, 8'd0, 32'd3, 3, 8'h12);
		commit_buffer();
		data_frame(32'd7, h2gfc_pkg::FLAG_PADDED, 8'd3, 32'd2, 2, 8'h08);
		commit_buffer();
		// padding runs past the end of the payload
		data_frame(32'd5, h2gfc_pkg::FLAG_PADDED, 8'd3, 32'd2, 2, 8'h08);
		frame_buf[9] = 8'hF0;
		commit_buffer();
		// zero message length, field number zero, wire type six, message cut short
		data_frame(32'd1, 8'h00, 8'd0, 32'd0, 2, 8'h08);
		commit_buffer();
		data_frame(32'd1, 8'h00, 8'd0, 32'd2, 2, 8'h02);
		commit_buffer();
		data_frame(32'd1, 8'h00, 8'd0, 32'd2, 2, 8'h0E);
		commit_buffer();
		data_frame(32'd1, 8'h00, 8'd0, 32'd9, 2, 8'h08);
		commit_buffer();
		// empty data frame, data frame on stream zero
		put_header(24'd0, h2gfc_pkg::FT_DATA, 8'h00, 32'd1);
		commit_buffer();
		data_frame(32'd0, 8'h00, 8'd0, 32'd2, 2, 8'h08);
		commit_buffer();
		// headers: plain, short priority block, no room for pad length, oversized padding
		put_header(24'd4, h2gfc_pkg::FT_HEADERS, 8'h00, 32'd3);
		put_random(4);
		commit_buffer();
		put_header(24'd3, h2gfc_pkg::FT_HEADERS, h2gfc_pkg::FLAG_PRIORITY, 32'd3);
		put_random(3);
		commit_buffer();
		put_header(24'd5, h2gfc_pkg::FT_HEADERS,
			h2gfc_pkg::FLAG_PRIORITY | h2gfc_pkg::FLAG_PADDED, 32'd3);
		put_random(5);
		commit_buffer();
		put_header(24'd4, h2gfc_pkg::FT_HEADERS, h2gfc_pkg::FLAG_PADDED, 32'd3);
		frame_buf.push_back(8'd200);
		put_random(3);
		commit_buffer();
		// control frames count a call; a stream reset on stream zero is malformed
		control_frame(h2gfc_pkg::FT_STREAM_RESET, 32'd1);
		control_frame(h2gfc_pkg::FT_SETTINGS, 32'd0);
		control_frame(h2gfc_pkg::FT_PING, 32'd0);
		control_frame(h2gfc_pkg::FT_GOAWAY, 32'd0);
		control_frame(h2gfc_pkg::FT_WINDOW_UPDATE, 32'd0);
		control_frame(h2gfc_pkg::FT_STREAM_RESET, 32'd0);
		// types that pass uncounted, then an unknown type
		control_frame(FT_PRIORITY, 32'd1);
		control_frame(FT_PUSH_PROMISE, 32'd1);
		control_frame(FT_CONTINUATION, 32'd1);
		control_frame(FT_FIRST_UNKNOWN, 32'd1);
		// length over the limit, frame cut short, bytes past the frame
		put_header(h2gfc_pkg::MAX_FRAME_RESET + 24'd1, h2gfc_pkg::FT_DATA, 8'h00, 32'd1);
		put_random(2);
		commit_buffer();
		data_frame(32'd3, 8'h00, 8'd0, 32'd3, 3, 8'h0A);
		void'(frame_buf.pop_back());
		void'(frame_buf.pop_back());
		commit_buffer();
		data_frame(32'd4, 8'h00, 8'd0, 32'd3, 3, 8'h0A);
		put_random(4);
		commit_buffer();
	endtask

	// mostly well-formed frames with random content, plus prefaces, stubs and noise
	task automatic random_buffer();
		int unsigned pick;
		int unsigned n;
		int unsigned body_n;
		logic [7:0]  flags;
		logic [7:0]  tag;
		logic [7:0]  ftype;
		logic [31:0] mlen;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			body_n = $urandom_range(0, 12);
			flags = ($urandom_range(0, 3) == 0) ? h2gfc_pkg::FLAG_PADDED : 8'h00;
			if ($urandom_range(0, 4) == 0)
				flags = flags | (8'($urandom) & ~h2gfc_pkg::FLAG_PADDED);
			case ($urandom_range(0, 9))
				0: mlen = $urandom;
				1, 2: mlen = $urandom_range(0, 16);
				default: mlen = body_n;
			endcase
			if ($urandom_range(0, 4) == 0)
				tag = 8'($urandom);
			else
				tag = {5'($urandom_range(1, 31)), 3'($urandom_range(0, 5))};
			data_frame(rand_stream(), flags, 8'($urandom_range(0, 4)), mlen, body_n, tag);
			// now and then a pad length the frame cannot hold
			if ((flags & h2gfc_pkg::FLAG_PADDED) != 0 && $urandom_range(0, 5) == 0)
				frame_buf[9] = 8'($urandom);
		end else if (pick < 55) begin
			n = $urandom_range(0, 12);
			case ($urandom_range(0, 4))
				0: flags = 8'h00;
				1: flags = h2gfc_pkg::FLAG_PADDED;
				2: flags = h2gfc_pkg::FLAG_PRIORITY;
				3: flags = h2gfc_pkg::FLAG_PADDED | h2gfc_pkg::FLAG_PRIORITY;
				default: flags = 8'($urandom);
			endcase
			put_header(24'(n), h2gfc_pkg::FT_HEADERS, flags, rand_stream());
			repeat (n) begin
				frame_buf.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 12))
					: 8'($urandom));
			end
		end else if (pick < 70) begin
			case ($urandom_range(0, 4))
				0: ftype = h2gfc_pkg::FT_STREAM_RESET;
				1: ftype = h2gfc_pkg::FT_SETTINGS;
				2: ftype = h2gfc_pkg::FT_PING;
				3: ftype = h2gfc_pkg::FT_GOAWAY;
				default: ftype = h2gfc_pkg::FT_WINDOW_UPDATE;
			endcase
			n = $urandom_range(0, 8);
			put_header(24'(n), ftype, 8'($urandom),
				($urandom_range(0, 1) != 0) ? 32'd0 : rand_stream());
			put_random(n);
		end else if (pick < 77) begin
			case ($urandom_range(0, 3))
				0: ftype = FT_PRIORITY;
				1: ftype = FT_PUSH_PROMISE;
				2: ftype = FT_CONTINUATION;
				default: ftype = 8'($urandom_range(FT_FIRST_UNKNOWN, 255));
			endcase
			n = $urandom_range(0, 8);
			put_header(24'(n), ftype, 8'($urandom), rand_stream());
			put_random(n);
		end else if (pick < 82) begin
			put_preface();
			case ($urandom_range(0, 3))
				0: frame_buf[$urandom_range(0, 23)] ^= 8'($urandom_range(1, 255));
				1: put_random($urandom_range(1, 5));
				2: repeat ($urandom_range(1, 15)) void'(frame_buf.pop_back());
				default: ;
			endcase
		end else if (pick < 87) begin
			put_random($urandom_range(1, 8));
		end else begin
			put_random($urandom_range(1, 30));
		end
		// frames sometimes gain trailing bytes or lose their tail
		if (pick < 77) begin
			case ($urandom_range(0, 9))
				0: put_random($urandom_range(1, 4));
				1: repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
				default: ;
			endcase
		end
		commit_buffer();
	endtask

	task automatic random_phase(input int unsigned n_bytes);
		int unsigned start;
		start = bytes_queued;
		while (bytes_queued - start < n_bytes)
			random_buffer();
	endtask

	// everything sent, every verdict seen, pipeline drained
	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_frame(input logic [23:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		max_frame = value;
	endtask

	// ---------------------------------------------------------------------
	// request driver: bursts of random length separated by random gaps
	// ---------------------------------------------------------------------
	logic        req_taken = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	byte_req_t   next_req;

	// the block takes a request on any edge with valid high and stall low
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_byte(data_byte, last);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		// a stalled request stays on the bus unchanged
		if (req_taken || !in_valid) begin
			req_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				next_req = pending_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_req.data;
				last <= next_req.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					// a quarter of the bursts run straight into the next
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// result sink: stall behavior switches between free, light, heavy and periodic
	// ---------------------------------------------------------------------
	sink_mode_t  sink_mode = SINK_FREE;
	int unsigned sink_tick = 0;

	always @(negedge clk) begin
		sink_tick++;
		if (sink_tick % 96 == 0)
			sink_mode = sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
			SINK_FREE: out_stall <= 1'b0;
			SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			SINK_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= sink_tick[2];
		endcase
	end

	// ---------------------------------------------------------------------
	// result checker: oldest verdict against each accepted result
	// ---------------------------------------------------------------------
	frame_verdict_t oldest;

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$error("result with no buffer waiting: status %0d", status);
				mismatch_count++;
			end else begin
				oldest = verdict_q.pop_front();
				check_field("status", 32'(oldest.status), 32'(status));
				check_field("counted", 32'(oldest.counted), 32'(counted));
				check_field("message_kind", 32'(oldest.kind), 32'(message_kind));
				check_field("call_count", oldest.calls, call_count);
				check_field("request_byte_total", oldest.req_bytes, request_byte_total);
				check_field("response_byte_total", oldest.resp_bytes, response_byte_total);
			end
		end
	end

	// watchdog: too long with neither channel moving means the block hung
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// test sequence: one reset, then phases under different frame size limits
	// ---------------------------------------------------------------------
	initial begin
		restart_buffer();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limit
		directed_buffers();
		random_phase(210);
		wait_idle();

		// no payload allowed at all
		set_max_frame(24'd0);
		random_phase(210);
		wait_idle();

		// largest limit the register holds
		set_max_frame(24'hFFFFFF);
		random_phase(210);
		wait_idle();

		// tight limit, about the size of the generated frames
		set_max_frame(24'($urandom_range(5, 40)));
		random_phase(210);
		wait_idle();

		// back to the default
		set_max_frame(h2gfc_pkg::MAX_FRAME_RESET);
		random_phase(210);
		wait_idle();

		if (mismatch_count == 0 && verdict_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
